// ----- rtl/keyed_fifo_with_lookup_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the keyed FIFO with lookup
// Shared property forms for the checker, clocked on clock, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef KEYED_FIFO_WITH_LOOKUP_ASSERT_SVH
`define KEYED_FIFO_WITH_LOOKUP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define KFL_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define KFL_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/kfl_pkg.sv -----
// ----------------------------------------------------------------------------
// kfl_pkg
// Types and constants shared by the keyed FIFO with lookup.
// ----------------------------------------------------------------------------
package kfl_pkg;

   localparam int DEFAULT_QUEUE_DEPTH = 16;
   localparam int KEY_WIDTH           = 32;
   localparam int DATA_WIDTH          = 32;
   localparam int ENTRY_COUNT_WIDTH   = 5;

   typedef enum logic [1:0] {
      OP_ENQUEUE = 2'd0,
      OP_DEQUEUE = 2'd1,
      OP_UPDATE  = 2'd2,
      OP_PEEK    = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_DUPLICATE = 3'd1,
      ST_EMPTY     = 3'd2,
      ST_NOT_FOUND = 3'd3,
      ST_FULL      = 3'd4
   } status_type;

   typedef struct packed {
      op_type                        op;
      logic signed [KEY_WIDTH-1:0]   key;
      logic signed [DATA_WIDTH-1:0]  data;
   } req_type;

   typedef struct packed {
      status_type                         status;
      logic signed [DATA_WIDTH-1:0]       data_out;
      logic [ENTRY_COUNT_WIDTH-1:0]       entry_count;
   } rsp_type;

   typedef struct packed {
      logic shift;
      logic load;
      logic update;
   } cell_ctrl_type;

endpackage

// ----- rtl/kfl_cell.sv -----
// ----------------------------------------------------------------------------
// kfl_cell
// One queue position: holds a key/data pair, compares its key with the
// request key, and takes its neighbor's entry when the queue advances.
// ----------------------------------------------------------------------------
module kfl_cell (
   input  logic                                   clock,
   input  kfl_pkg::cell_ctrl_type                 ctrl,
   input  logic                                   live,
   input  logic signed [kfl_pkg::KEY_WIDTH-1:0]   req_key,
   input  logic signed [kfl_pkg::DATA_WIDTH-1:0]  req_data,
   input  logic signed [kfl_pkg::KEY_WIDTH-1:0]   next_key,
   input  logic signed [kfl_pkg::DATA_WIDTH-1:0]  next_data,
   output logic signed [kfl_pkg::KEY_WIDTH-1:0]   key,
   output logic signed [kfl_pkg::DATA_WIDTH-1:0]  data,
   output logic                                   hit
);
   import kfl_pkg::*;

   logic signed [KEY_WIDTH-1:0]  key_ff, key_in;
   logic signed [DATA_WIDTH-1:0] data_ff, data_in;

   assign hit = live && (key_ff == req_key);

   always_comb begin
      key_in  = key_ff;
      data_in = data_ff;
      if (ctrl.shift) begin
         key_in  = next_key;
         data_in = next_data;
      end else if (ctrl.load) begin
         key_in  = req_key;
         data_in = req_data;
      end else if (ctrl.update && hit) begin
         data_in = req_data;
      end
   end

   always_ff @(posedge clock) begin
      key_ff  <= key_in;
      data_ff <= data_in;
   end

   assign key  = key_ff;
   assign data = data_ff;

endmodule

// ----- rtl/keyed_fifo_with_lookup.sv -----
// ----------------------------------------------------------------------------
// keyed_fifo_with_lookup
// Bounded FIFO of unique-key entries held in a row of cells, with
// enqueue, dequeue, update-by-key and peek-by-key operations.
// ----------------------------------------------------------------------------
// The block takes one request per cycle and returns its result from an output
// register in the cycle after the transfer; while rsp_ready stays high it sustains
// one operation per clock. The figure is set by the row of QUEUE_DEPTH cells:
// every cell compares its key with the request key in the same cycle, and on a
// dequeue every cell takes its neighbor's entry at once, so cell 0 is always
// the head. A new request is taken whenever the result register is empty or
// being drained. entry_count reports the low five bits of the entry count.
module keyed_fifo_with_lookup #(
   parameter int QUEUE_DEPTH = kfl_pkg::DEFAULT_QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  kfl_pkg::req_type req_item,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output kfl_pkg::rsp_type rsp_item
);
   import kfl_pkg::*;

   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   logic [CW-1:0] count_ff, count_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_item_ff, rsp_item_in;

   logic signed [KEY_WIDTH-1:0]  cell_key  [QUEUE_DEPTH];
   logic signed [DATA_WIDTH-1:0] cell_data [QUEUE_DEPTH];
   logic [QUEUE_DEPTH-1:0]       cell_hit;

   logic                         accept;
   logic                         any_hit;
   logic signed [DATA_WIDTH-1:0] hit_data;
   logic                         full;
   logic                         empty;
   logic                         enq_ok, deq_ok, upd_ok;
   status_type                   status;
   logic signed [DATA_WIDTH-1:0] dout;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign full      = (count_ff == CW'(QUEUE_DEPTH));
   assign empty     = (count_ff == '0);

   always_comb begin
      hit_data = '0;
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         if (cell_hit[i]) begin
            hit_data = hit_data | cell_data[i];
         end
      end
   end

   assign any_hit = |cell_hit;

   always_comb begin
      status   = ST_OK;
      dout     = '0;
      enq_ok   = 1'b0;
      deq_ok   = 1'b0;
      upd_ok   = 1'b0;
      count_in = count_ff;
      case (req_item.op)
         OP_ENQUEUE: begin
            if (any_hit) begin
               status = ST_DUPLICATE;
            end else if (full) begin
               status = ST_FULL;
            end else begin
               enq_ok   = 1'b1;
               count_in = count_ff + 1'b1;
            end
         end
         OP_DEQUEUE: begin
            if (empty) begin
               status = ST_EMPTY;
            end else begin
               deq_ok   = 1'b1;
               count_in = count_ff - 1'b1;
            end
         end
         OP_UPDATE: begin
            if (any_hit) begin
               upd_ok = 1'b1;
            end else begin
               status = ST_NOT_FOUND;
            end
         end
         OP_PEEK: begin
            if (any_hit) begin
               dout = hit_data;
            end else begin
               status = ST_NOT_FOUND;
            end
         end
         default: begin
            status = ST_NOT_FOUND;
         end
      endcase
      if (!accept) begin
         count_in = count_ff;
      end
   end

   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      cell_ctrl_type                ctrl;
      logic signed [KEY_WIDTH-1:0]  next_key;
      logic signed [DATA_WIDTH-1:0] next_data;

      assign ctrl.shift  = accept && deq_ok;
      assign ctrl.load   = accept && enq_ok && (count_ff == CW'(i));
      assign ctrl.update = accept && upd_ok;

      if (i == QUEUE_DEPTH - 1) begin : g_tail
         assign next_key  = cell_key[i];
         assign next_data = cell_data[i];
      end else begin : g_body
         assign next_key  = cell_key[i+1];
         assign next_data = cell_data[i+1];
      end

      kfl_cell u_cell (
         .clock     (clock),
         .ctrl      (ctrl),
         .live      (CW'(i) < count_ff),
         .req_key   (req_item.key),
         .req_data  (req_item.data),
         .next_key  (next_key),
         .next_data (next_data),
         .key       (cell_key[i]),
         .data      (cell_data[i]),
         .hit       (cell_hit[i])
      );
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_item_in  = rsp_item_ff;
      if (accept) begin
         rsp_valid_in             = 1'b1;
         rsp_item_in.status       = status;
         rsp_item_in.data_out     = dout;
         rsp_item_in.entry_count  = ENTRY_COUNT_WIDTH'(count_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule

// ----- rtl/kfl_checker.sv -----
// ----------------------------------------------------------------------------
// kfl_checker
// Port-level checks for the keyed FIFO with lookup, bound to the top level.
// ----------------------------------------------------------------------------
`include "keyed_fifo_with_lookup_assert.svh"

module kfl_checker #(
   parameter int QUEUE_DEPTH = kfl_pkg::DEFAULT_QUEUE_DEPTH
) (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input kfl_pkg::rsp_type rsp_item
);
   import kfl_pkg::*;

   localparam int CountLimit = QUEUE_DEPTH;

   logic rsp_stall;
   logic req_xfer;
   logic rsp_fail;
   logic rsp_empty;
   logic count_clear;

   assign rsp_stall   = rsp_valid && !rsp_ready;
   assign req_xfer    = req_valid && req_ready;
   assign rsp_fail    = rsp_valid && (rsp_item.status != ST_OK);
   assign rsp_empty   = rsp_valid && (rsp_item.status == ST_EMPTY);
   assign count_clear = (rsp_item.entry_count == '0) && (CountLimit > 0);

   `KFL_ASSERT_NEXT(a_rsp_hold, rsp_stall, rsp_valid && $stable(rsp_item), "result changed in stall")
   `KFL_ASSERT_NEXT(a_rsp_follows, req_xfer, rsp_valid, "transfer gave no result")
   `KFL_ASSERT_NOW(a_data_zero, rsp_fail, rsp_item.data_out == '0, "data_out set on failure")
   `KFL_ASSERT_NOW(a_empty_count, rsp_empty, count_clear, "empty status with entries held")

endmodule

bind keyed_fifo_with_lookup kfl_checker #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_kfl_checker (.*);

// ----- dv/tb_keyed_fifo_with_lookup.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_keyed_fifo_with_lookup
// Self-checking bench for the keyed FIFO: directed tests for the empty queue,
// extreme keys and data, and a full queue. Random traffic follows, shaped as
// runs of fills, drains and mixed access, under four idle/stall profiles.
// A mirror of the held entries predicts each response in transfer order.
// ----------------------------------------------------------------------------
module tb_keyed_fifo_with_lookup;
   import kfl_pkg::*;

   localparam int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH;
   localparam int STALL_LIMIT = 2000;
   localparam int REPORT_LIMIT = 10;

   logic    clock;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_item  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_item;

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int error_count    = 0;
   int quiet_cycles   = 0;

   logic [KEY_WIDTH-1:0]  held_keys[$];
   logic [DATA_WIDTH-1:0] held_data[$];
   rsp_type               pending_responses[$];

   keyed_fifo_with_lookup #(.QUEUE_DEPTH(QUEUE_DEPTH)) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic void note_failure(input string msg);
      error_count++;
      if (error_count <= REPORT_LIMIT) begin
         $display("%0t: mismatch: %s", $realtime, msg);
      end
   endfunction

   // Apply one operation to the mirror and return the response it must give.
   function automatic rsp_type predict_response(input req_type item);
      rsp_type r;
      int      slot;
      slot = -1;
      for (int i = 0; i < held_keys.size(); i++) begin
         if (slot < 0 && held_keys[i] == item.key) begin
            slot = i;
         end
      end
      r.status   = ST_OK;
      r.data_out = '0;
      case (item.op)
         OP_ENQUEUE: begin
            if (slot >= 0) begin
               r.status = ST_DUPLICATE;
            end else if (held_keys.size() >= QUEUE_DEPTH) begin
               r.status = ST_FULL;
            end else begin
               held_keys.push_back(item.key);
               held_data.push_back(item.data);
            end
         end
         OP_DEQUEUE: begin
            if (held_keys.size() == 0) begin
               r.status = ST_EMPTY;
            end else begin
               void'(held_keys.pop_front());
               void'(held_data.pop_front());
            end
         end
         OP_UPDATE: begin
            if (slot >= 0) begin
               held_data[slot] = item.data;
            end else begin
               r.status = ST_NOT_FOUND;
            end
         end
         default: begin
            if (slot >= 0) begin
               r.data_out = held_data[slot];
            end else begin
               r.status = ST_NOT_FOUND;
            end
         end
      endcase
      r.entry_count = ENTRY_COUNT_WIDTH'(held_keys.size());
      return r;
   endfunction

   task automatic send_request(input op_type op, input logic [KEY_WIDTH-1:0] key,
                               input logic [DATA_WIDTH-1:0] data);
      req_type item;
      item.op   = op;
      item.key  = key;
      item.data = data;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_item  <= item;
      do @(posedge clock); while (!req_ready);
      pending_responses.push_back(predict_response(item));
   endtask

   task automatic test_empty_queue();
      send_request(OP_DEQUEUE, 32'h0000_0000, 32'hFFFF_FFFF);
      send_request(OP_UPDATE,  32'h0000_0000, 32'h1234_5678);
      send_request(OP_PEEK,    32'hFFFF_FFFF, 32'h0000_0000);
   endtask

   task automatic test_extreme_fields();
      send_request(OP_ENQUEUE, 32'h8000_0000, 32'h7FFF_FFFF);
      send_request(OP_ENQUEUE, 32'h7FFF_FFFF, 32'h8000_0000);
      send_request(OP_ENQUEUE, 32'h0000_0000, 32'hFFFF_FFFF);
      send_request(OP_ENQUEUE, 32'hFFFF_FFFF, 32'h0000_0000);
      send_request(OP_ENQUEUE, 32'h7FFF_FFFF, 32'h5555_5555);
      send_request(OP_UPDATE,  32'hFFFF_FFFF, 32'hAAAA_AAAA);
      send_request(OP_PEEK,    32'hFFFF_FFFF, 32'h0000_0000);
      send_request(OP_PEEK,    32'h8000_0000, 32'hFFFF_FFFF);
      send_request(OP_PEEK,    32'h5A5A_5A5A, 32'h0000_0000);
      send_request(OP_DEQUEUE, 32'h7FFF_FFFF, 32'h0000_0000);
   endtask

   task automatic test_full_queue();
      logic [KEY_WIDTH-1:0] head_key;
      while (held_keys.size() < QUEUE_DEPTH) begin
         send_request(OP_ENQUEUE, 32'h0000_0100 + held_keys.size(), $urandom);
      end
      head_key = held_keys[0];
      send_request(OP_ENQUEUE, 32'h0BAD_F00D, $urandom);
      send_request(OP_ENQUEUE, head_key, $urandom);
      send_request(OP_UPDATE, held_keys[QUEUE_DEPTH-1], 32'hC0DE_0001);
      send_request(OP_PEEK, held_keys[QUEUE_DEPTH-1], 32'h0000_0000);
   endtask

   task automatic test_random_traffic(input int item_total, input int idle_pct,
                                      input int stall_pct);
      int                   run_left;
      int                   enq_cut;
      int                   deq_cut;
      int                   upd_cut;
      int                   roll;
      op_type               op;
      logic [KEY_WIDTH-1:0] key;
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      run_left       = 0;
      for (int n = 0; n < item_total; n++) begin
         if (run_left == 0) begin
            run_left = $urandom_range(20, 60);
            case ($urandom_range(2))
               0:       begin enq_cut = 60; deq_cut = 75; upd_cut = 87; end
               1:       begin enq_cut = 15; deq_cut = 70; upd_cut = 85; end
               default: begin enq_cut = 30; deq_cut = 55; upd_cut = 78; end
            endcase
         end
         run_left--;
         roll = $urandom_range(99);
         op = (roll < enq_cut) ? OP_ENQUEUE :
              (roll < deq_cut) ? OP_DEQUEUE :
              (roll < upd_cut) ? OP_UPDATE  : OP_PEEK;
         if (held_keys.size() != 0 &&
             $urandom_range(99) < ((op == OP_ENQUEUE) ? 20 : 75)) begin
            key = held_keys[$urandom_range(held_keys.size() - 1)];
         end else begin
            key = $urandom;
         end
         send_request(op, key, $urandom);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_responses.size() == 0) begin
            note_failure($sformatf("response with none pending: %p", rsp_item));
         end else begin
            want = pending_responses.pop_front();
            if (rsp_item.status !== want.status) begin
               note_failure($sformatf("status expected %s got %0d",
                                      want.status.name(), rsp_item.status));
            end
            if (rsp_item.data_out !== want.data_out) begin
               note_failure($sformatf("data_out expected %h got %h",
                                      want.data_out, rsp_item.data_out));
            end
            if (rsp_item.entry_count !== want.entry_count) begin
               note_failure($sformatf("entry_count expected %0d got %0d",
                                      want.entry_count, rsp_item.entry_count));
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      test_empty_queue();
      test_extreme_fields();
      test_full_queue();
      test_random_traffic(180, 0, 0);
      test_random_traffic(180, 54, 0);
      test_random_traffic(180, 0, 54);
      test_random_traffic(180, 9, 9);
      req_valid <= 1'b0;
      while (pending_responses.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      if (error_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
